// File: rtl/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared types, constants and helpers of the pooled fixed-block allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

  // Slot and address geometry: an address is pool * 64 + slot
  localparam int unsigned SLOT_W          = 6;
  localparam int unsigned BLOCKS_PER_POOL = 64;
  localparam int unsigned CNT_W           = 7;
  localparam int unsigned ADDR_W          = 9;
  localparam int unsigned POOL_FIELD_W    = 3;
  localparam int unsigned TYPE_W          = 2;

  // Configuration registers
  localparam int unsigned NUM_CFG    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  // Free list head value for an empty list
  localparam logic [CNT_W-1:0]      EMPTY_SLOT   = CNT_W'(BLOCKS_PER_POOL);
  localparam logic [CFG_DATA_W-1:0] RESET_BLOCKS = CFG_DATA_W'(BLOCKS_PER_POOL);

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REJECT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_POOL  = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_e;

  // Classified word passed from the front end to the back end
  typedef struct packed {
    op_e                     op;
    logic [TYPE_W-1:0]       type_id;
    logic [POOL_FIELD_W-1:0] pool;
    logic [SLOT_W-1:0]       slot;
  } item_t;

  // Limit a configured pool size to 1..BLOCKS_PER_POOL
  function automatic logic [CNT_W-1:0] clamp_blocks(input logic [CFG_DATA_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = CNT_W'(n);
    if (r == '0) begin
      r = CNT_W'(1);
    end else if (r > EMPTY_SLOT) begin
      r = EMPTY_SLOT;
    end
    return r;
  endfunction

endpackage

// File: rtl/pfba_front.sv
// ----------------------------------------------------------------------------
// pfba_front
// Accepts request words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module pfba_front #(
  parameter int unsigned NUM_TYPES = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic [pfba_pkg::TYPE_W-1:0]         type_id_i,
  input  logic [pfba_pkg::ADDR_W-1:0]         block_address_i,
  output logic                                item_valid_o,
  output pfba_pkg::item_t                     item_o,
  input  logic                                item_pop_i
);
  import pfba_pkg::*;

  item_t       fifo_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  item_t       item_new;
  logic        push, pop;

  // Classify the incoming word
  always_comb begin
    item_new.type_id = type_id_i;
    item_new.pool    = block_address_i[ADDR_W-1:SLOT_W];
    item_new.slot    = block_address_i[SLOT_W-1:0];
    if (cmd_i) begin
      item_new.op = OP_FREE;
    end else if (32'(type_id_i) < NUM_TYPES) begin
      item_new.op = OP_ALLOC;
    end else begin
      item_new.op = OP_REJECT;
    end
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = fifo_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  // Advance queue pointers
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the classified word
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

// File: rtl/pfba_back.sv
// ----------------------------------------------------------------------------
// pfba_back
// Executes allocations and frees against the pool state and slot memory,
// and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module pfba_back #(
  parameter int unsigned NUM_POOLS = 8,
  parameter int unsigned NUM_TYPES = 4
) (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  logic                                                    item_valid_i,
  input  pfba_pkg::item_t                                         item_i,
  output logic                                                    item_pop_o,
  input  logic [pfba_pkg::NUM_CFG-1:0][pfba_pkg::CFG_DATA_W-1:0]  blocks_cfg_i,
  output logic                                                    out_valid_o,
  input  logic                                                    out_ready_i,
  output logic [pfba_pkg::ADDR_W-1:0]                             granted_address_o,
  output pfba_pkg::status_e                                       status_o,
  output logic                                                    pool_released_o
);
  import pfba_pkg::*;

  localparam int unsigned PW    = $clog2(NUM_POOLS);
  localparam int unsigned TW    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int unsigned AW    = PW + SLOT_W;
  localparam int unsigned DEPTH = NUM_POOLS * BLOCKS_PER_POOL;

  typedef enum logic [1:0] {
    S_READ = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Per-pool state
  logic [CNT_W-1:0] head_q   [NUM_POOLS];
  logic [CNT_W-1:0] fresh_q  [NUM_POOLS];
  logic [CNT_W-1:0] nblk_q   [NUM_POOLS];
  logic [CNT_W-1:0] used_q   [NUM_POOLS];
  logic             active_q [NUM_POOLS];
  logic [TW-1:0]    owner_q  [NUM_POOLS];
  logic [PW-1:0]    ring_prev_q [NUM_POOLS];
  logic [PW-1:0]    ring_next_q [NUM_POOLS];
  // Per-type state
  logic [PW-1:0]    cur_pool_q [NUM_TYPES];
  logic             has_pool_q [NUM_TYPES];

  // Slot memory: {busy, link}
  logic [CNT_W:0]   slot_mem [DEPTH];
  logic [CNT_W:0]   rdata_q;
  logic [AW-1:0]    raddr, waddr;
  logic [CNT_W:0]   wdata;
  logic             mem_we;

  // Result register
  logic              out_valid_q;
  logic [ADDR_W-1:0] granted_q, granted_d;
  status_e           status_q, status_d;
  logic              released_q;

  logic             exec_fire;
  logic [TW-1:0]    ti;
  logic [PW-1:0]    curp;
  logic             need_new;
  logic             spare_found;
  logic [PW-1:0]    spare_pool;
  logic [PW-1:0]    a_pool;
  logic [CNT_W-1:0] a_head, a_fresh, a_nblk, a_used, a_head_inc, a_next, a_fresh_n;
  logic             a_is_fresh;
  logic             alloc_ok;
  logic [PW-1:0]    f_pool;
  logic             f_pool_ok, f_busy, free_ok, f_release;
  logic [CNT_W-1:0] f_used_n;
  logic [TW-1:0]    f_owner;

  assign exec_fire  = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign item_pop_o = exec_fire;

  // Sequence read then execute
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_READ:  if (item_valid_i) state_d = S_EXEC;
      S_EXEC:  if (exec_fire) state_d = S_READ;
      default: state_d = S_READ;
    endcase
  end

  // Find the lowest inactive pool
  always_comb begin
    spare_found = 1'b0;
    spare_pool  = '0;
    for (int i = NUM_POOLS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        spare_found = 1'b1;
        spare_pool  = PW'(i);
      end
    end
  end

  // Allocation path
  always_comb begin
    ti         = TW'(item_i.type_id);
    curp       = cur_pool_q[ti];
    need_new   = !has_pool_q[ti] || (head_q[curp] == EMPTY_SLOT);
    a_pool     = need_new ? spare_pool : curp;
    a_head     = need_new ? '0 : head_q[curp];
    a_fresh    = need_new ? '0 : fresh_q[curp];
    a_used     = need_new ? '0 : used_q[curp];
    a_nblk     = need_new ? clamp_blocks(blocks_cfg_i[item_i.type_id]) : nblk_q[curp];
    a_is_fresh = (a_head == a_fresh);
    a_head_inc = a_head + CNT_W'(1);
    // Slots at or past the fresh mark form an implicit ascending list
    if (a_is_fresh) begin
      a_next = (a_head_inc < a_nblk) ? a_head_inc : EMPTY_SLOT;
    end else begin
      a_next = rdata_q[CNT_W-1:0];
    end
    a_fresh_n  = a_is_fresh ? a_head_inc : a_fresh;
    alloc_ok   = (item_i.op == OP_ALLOC) && (!need_new || spare_found);
  end

  // Free path
  always_comb begin
    f_pool    = PW'(item_i.pool);
    f_pool_ok = (32'(item_i.pool) < NUM_POOLS) && active_q[f_pool];
    f_busy    = ({1'b0, item_i.slot} < fresh_q[f_pool]) && rdata_q[CNT_W];
    free_ok   = (item_i.op == OP_FREE) && f_pool_ok && f_busy;
    f_used_n  = (used_q[f_pool] != '0) ? (used_q[f_pool] - CNT_W'(1)) : '0;
    f_release = (f_used_n == '0) && (ring_next_q[f_pool] != f_pool);
    f_owner   = owner_q[f_pool];
  end

  // Memory addresses and result word
  always_comb begin
    raddr     = (item_i.op == OP_FREE) ? {f_pool, item_i.slot}
                                       : {curp, head_q[curp][SLOT_W-1:0]};
    mem_we    = exec_fire && (alloc_ok || free_ok);
    waddr     = alloc_ok ? {a_pool, a_head[SLOT_W-1:0]} : {f_pool, item_i.slot};
    wdata     = alloc_ok ? {1'b1, CNT_W'(0)} : {1'b0, head_q[f_pool]};
    granted_d = alloc_ok ? ADDR_W'({a_pool, a_head[SLOT_W-1:0]}) : '0;
    case (item_i.op)
      OP_ALLOC: status_d = alloc_ok ? ST_OK : ST_NO_POOL;
      OP_FREE:  status_d = free_ok ? ST_OK : ST_BAD_FREE;
      default:  status_d = ST_NO_POOL;
    endcase
  end

  // Read and write the slot memory
  always_ff @(posedge clk_i) begin
    if (state_q == S_READ && item_valid_i) begin
      rdata_q <= slot_mem[raddr];
    end
    if (mem_we) begin
      slot_mem[waddr] <= wdata;
    end
  end

  // Update pool state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_READ;
      for (int p = 0; p < NUM_POOLS; p++) begin
        head_q[p]      <= (p < NUM_TYPES) ? '0 : EMPTY_SLOT;
        fresh_q[p]     <= '0;
        nblk_q[p]      <= clamp_blocks(RESET_BLOCKS);
        used_q[p]      <= '0;
        active_q[p]    <= (p < NUM_TYPES);
        owner_q[p]     <= (p < NUM_TYPES) ? TW'(p) : '0;
        ring_prev_q[p] <= PW'(p);
        ring_next_q[p] <= PW'(p);
      end
      for (int t = 0; t < NUM_TYPES; t++) begin
        cur_pool_q[t] <= (t < NUM_POOLS) ? PW'(t) : '0;
        has_pool_q[t] <= (t < NUM_POOLS);
      end
    end else begin
      state_q <= state_d;
      if (exec_fire && alloc_ok) begin
        if (need_new) begin
          active_q[a_pool] <= 1'b1;
          owner_q[a_pool]  <= ti;
          nblk_q[a_pool]   <= a_nblk;
          cur_pool_q[ti]   <= a_pool;
          if (has_pool_q[ti]) begin
            ring_prev_q[a_pool]            <= curp;
            ring_next_q[a_pool]            <= ring_next_q[curp];
            ring_prev_q[ring_next_q[curp]] <= a_pool;
            ring_next_q[curp]              <= a_pool;
          end else begin
            ring_prev_q[a_pool] <= a_pool;
            ring_next_q[a_pool] <= a_pool;
            has_pool_q[ti]      <= 1'b1;
          end
        end
        head_q[a_pool]  <= a_next;
        fresh_q[a_pool] <= a_fresh_n;
        used_q[a_pool]  <= a_used + CNT_W'(1);
      end
      if (exec_fire && free_ok) begin
        used_q[f_pool] <= f_used_n;
        if (f_release) begin
          // Unlink the emptied pool and drop it
          if (cur_pool_q[f_owner] == f_pool) begin
            cur_pool_q[f_owner] <= ring_next_q[f_pool];
          end
          ring_next_q[ring_prev_q[f_pool]] <= ring_next_q[f_pool];
          ring_prev_q[ring_next_q[f_pool]] <= ring_prev_q[f_pool];
          ring_next_q[f_pool]              <= f_pool;
          ring_prev_q[f_pool]              <= f_pool;
          active_q[f_pool]                 <= 1'b0;
          head_q[f_pool]                   <= EMPTY_SLOT;
        end else begin
          head_q[f_pool] <= {1'b0, item_i.slot};
        end
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      granted_q  <= granted_d;
      status_q   <= status_d;
      released_q <= free_ok && f_release;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = granted_q;
  assign status_o          = status_q;
  assign pool_released_o   = released_q;

`ifndef SYNTH
  a_load_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result loaded outside execute step");

  a_fail_no_address: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_OK) |-> (granted_q == '0))
    else $error("failed request carries an address");

  a_release_ok_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && released_q) |-> (status_q == ST_OK))
    else $error("pool released on a failed request");

  a_cur_pool_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_pool_q[0] |-> active_q[cur_pool_q[0]])
    else $error("current pool of type 0 is inactive");

  a_exec_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> item_valid_i)
    else $error("execute step without a queued word");
`endif

endmodule

// File: rtl/pooled_fixed_block_allocator.sv
// ----------------------------------------------------------------------------
// pooled_fixed_block_allocator
// Fixed-block allocator over a set of pools with per-pool LIFO free lists.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o | cmd_i type_id_i block_address_i
//  out     | output    | out_valid_o/out_ready_i | granted_address_o status_o
//          |           |                         | pool_released_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i cfg_data_i
//
//  In the back end, S_READ first reads the slot memory for a word; then
//  S_EXEC updates pool state, writes the slot memory and loads the result.
//  The single-port slot memory read-modify-write sets this split into steps.
//  A 2-entry queue lets the front end keep accepting while the back end waits.
//  Reset needs no clearing pass: a per-pool fresh mark stands in for the
//  untouched ascending part of each list. An output stall holds the back end.
// ----------------------------------------------------------------------------
module pooled_fixed_block_allocator #(
  parameter int unsigned NUM_POOLS = 8,
  parameter int unsigned NUM_TYPES = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic [pfba_pkg::TYPE_W-1:0]         type_id_i,
  input  logic [pfba_pkg::ADDR_W-1:0]         block_address_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pfba_pkg::ADDR_W-1:0]         granted_address_o,
  output logic [1:0]                          status_o,
  output logic                                pool_released_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pfba_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pfba_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import pfba_pkg::*;

  logic [NUM_CFG-1:0][CFG_DATA_W-1:0] blocks_cfg_q;
  logic    item_valid;
  item_t   item;
  logic    item_pop;
  status_e status;

  // Write configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        blocks_cfg_q[i] <= RESET_BLOCKS;
      end
    end else if (cfg_valid_i) begin
      blocks_cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  pfba_front #(
    .NUM_TYPES (NUM_TYPES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .type_id_i       (type_id_i),
    .block_address_i (block_address_i),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .item_pop_i      (item_pop)
  );

  pfba_back #(
    .NUM_POOLS (NUM_POOLS),
    .NUM_TYPES (NUM_TYPES)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (item_valid),
    .item_i            (item),
    .item_pop_o        (item_pop),
    .blocks_cfg_i      (blocks_cfg_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .granted_address_o (granted_address_o),
    .status_o          (status),
    .pool_released_o   (pool_released_o)
  );

  assign status_o = 2'(status);

endmodule
